// ===== src/etsa_pkg.sv =====
// shared types and codes for the edge-triggered snippet averager
// no dependencies; imported by etsa_front, etsa_back and the top level
package etsa_pkg;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} op_e_t;

	// decoded command as it sits in the queue between front and back
	typedef struct packed {
		op_e_t      kind;
		logic       sample_bit;
		logic [9:0] point_index;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_READ,
		ST_EMIT
	} back_state_t;

	// status from the back end
	typedef struct packed {
		logic       idle;
		logic [4:0] count;
	} stat_t;

	localparam int unsigned REG_RISING = 0;
	localparam int unsigned REG_PRE    = 1;
	localparam int unsigned REG_WINDOW = 2;
	localparam int unsigned REG_MAXAVG = 3;

endpackage

// ===== src/etsa_front.sv =====
// front end: accepts stream transactions, decodes them into commands
// and holds them in a two-entry queue; depends on etsa_pkg
module etsa_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,
	input  logic             s_axis_tuser,
	output logic             q_valid,
	output etsa_pkg::cmd_t   q_cmd,
	input  logic             q_pop
);
	import etsa_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       dec;

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != 2'd0);
	assign q_cmd         = buf_q[rd_ptr_q];

	// classify the transaction
	always_comb begin
		dec.kind        = s_axis_tuser ? OP_READ : OP_SAMPLE;
		dec.sample_bit  = s_axis_tdata[0];
		dec.point_index = s_axis_tdata[10:1];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/etsa_back.sv =====
// back end: sample history, trigger and capture control, snippet copy
// and the slot walk for reads; depends on etsa_pkg
module etsa_back #(
	parameter int MAX_WINDOW = 1024,
	parameter int SLOTS      = 30,
	localparam int AW = $clog2(MAX_WINDOW),
	localparam int LW = $clog2(MAX_WINDOW + 1),
	localparam int SW = $clog2(SLOTS),
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_clr,
	input  logic             rising,
	input  logic [LW-1:0]    eff_w,
	input  logic [LW-1:0]    eff_rem,
	input  logic [CW-1:0]    eff_max,
	input  logic             q_valid,
	input  etsa_pkg::cmd_t   q_cmd,
	output logic             q_pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,
	output etsa_pkg::stat_t  stat
);
	import etsa_pkg::*;

	localparam int MA = $clog2(SLOTS * MAX_WINDOW);

	logic        hist_mem [MAX_WINDOW];
	logic        snip_mem [SLOTS * MAX_WINDOW];

	back_state_t state_q, state_nx;

	logic [AW-1:0] head_q;
	logic          full_q;
	logic          prev_q;
	logic          active_q;
	logic [LW-1:0] pos_q;
	logic [SW-1:0] slot_q;
	logic [CW-1:0] count_q;

	logic [SW-1:0] copy_slot_q;
	logic [AW-1:0] cp_addr_q;
	logic [LW-1:0] cp_left_q;
	logic [AW-1:0] cp_k_q;
	logic          cp_v_s1;
	logic [AW-1:0] cp_k_s1;
	logic          hist_rd_s1;
	logic          hist_ok_s1;

	logic [SW-1:0] rd_slot_q;
	logic [CW-1:0] rd_left_q;
	logic [9:0]    rd_pt_q;
	logic          rd_v_s1;
	logic          snip_rd_s1;

	logic          res_trig_q;
	logic          res_stored_q;
	logic [CW-1:0] ones_q;
	logic          out_free;
	logic          emit;

	logic [LW-1:0] pos_dec;
	logic          edge_hit;
	logic          do_store;
	logic          trig;
	logic [CW-1:0] count_inc;
	logic [AW-1:0] head_nx;
	logic [LW:0]   start_sum;
	logic [AW-1:0] start_addr;
	logic          pt_in;
	logic          copy_done;
	logic          read_done;
	logic [MA-1:0] wr_addr;
	logic [MA-1:0] rd_addr;

	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign copy_done = (cp_left_q == '0) && !cp_v_s1;
	assign read_done = (rd_left_q == '0) && !rd_v_s1;

	always_comb begin
		pos_dec   = (pos_q != '0) ? pos_q - LW'(1) : '0;
		edge_hit  = rising ? (!prev_q && q_cmd.sample_bit) : (prev_q && !q_cmd.sample_bit);
		trig      = !active_q && edge_hit;
		do_store  = active_q ? (pos_dec == '0) : (edge_hit && (eff_rem == '0));
		count_inc = (count_q < eff_max) ? count_q + CW'(1) : eff_max;
		head_nx   = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
		// first history entry of the snippet, head minus window, modulo depth
		start_sum = (LW + 1)'(head_nx) + (LW + 1)'(MAX_WINDOW) - (LW + 1)'(eff_w);
		if (start_sum >= (LW + 1)'(MAX_WINDOW)) begin
			start_addr = AW'(start_sum - (LW + 1)'(MAX_WINDOW));
		end else begin
			start_addr = AW'(start_sum);
		end
		pt_in   = ((LW + 10)'(q_cmd.point_index) < (LW + 10)'(eff_w));
		wr_addr = MA'(copy_slot_q) * MA'(MAX_WINDOW) + MA'(cp_k_s1);
		rd_addr = MA'(rd_slot_q) * MA'(MAX_WINDOW) + MA'(rd_pt_q);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_cmd.kind == OP_SAMPLE) begin
						state_nx = do_store ? ST_COPY : ST_EMIT;
					end else begin
						state_nx = (pt_in && count_q != '0) ? ST_READ : ST_EMIT;
					end
				end
			end
			ST_COPY: begin
				if (copy_done) begin
					state_nx = ST_EMIT;
				end
			end
			ST_READ: begin
				if (read_done) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop      = (state_q == ST_IDLE) && q_valid;
		emit       = (state_q == ST_EMIT) && out_free;
		stat.idle  = (state_q == ST_IDLE);
		stat.count = 5'(count_q);
	end

	// memories
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == OP_SAMPLE) begin
			hist_mem[head_q] <= q_cmd.sample_bit;
		end
		hist_rd_s1 <= hist_mem[cp_addr_q];
		hist_ok_s1 <= full_q || (cp_addr_q < head_q);
		if (cp_v_s1) begin
			snip_mem[wr_addr] <= hist_rd_s1 && hist_ok_s1;
		end
		snip_rd_s1 <= snip_mem[rd_addr];
		cp_k_s1    <= cp_k_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_trig_q   <= (q_cmd.kind == OP_SAMPLE) && trig;
			res_stored_q <= (q_cmd.kind == OP_SAMPLE) && do_store;
			rd_pt_q      <= q_cmd.point_index;
		end
		if (emit) begin
			m_axis_tdata <= {4'b0, 5'(count_q), 5'(ones_q), res_stored_q, res_trig_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			head_q        <= '0;
			full_q        <= 1'b0;
			prev_q        <= 1'b0;
			active_q      <= 1'b0;
			pos_q         <= '0;
			slot_q        <= '0;
			count_q       <= '0;
			copy_slot_q   <= '0;
			cp_addr_q     <= '0;
			cp_left_q     <= '0;
			cp_k_q        <= '0;
			cp_v_s1       <= 1'b0;
			rd_slot_q     <= '0;
			rd_left_q     <= '0;
			rd_v_s1       <= 1'b0;
			ones_q        <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_nx;
			cp_v_s1 <= 1'b0;
			rd_v_s1 <= 1'b0;

			if (q_pop && q_cmd.kind == OP_SAMPLE) begin
				head_q <= head_nx;
				if (head_q == AW'(MAX_WINDOW - 1)) begin
					full_q <= 1'b1;
				end
				prev_q <= q_cmd.sample_bit;
				ones_q <= '0;
				if (active_q) begin
					pos_q <= pos_dec;
					if (pos_dec == '0) begin
						active_q <= 1'b0;
					end
				end else if (edge_hit && eff_rem != '0) begin
					active_q <= 1'b1;
					pos_q    <= eff_rem;
				end
				if (do_store) begin
					copy_slot_q <= slot_q;
					slot_q      <= (slot_q == SW'(SLOTS - 1)) ? '0 : slot_q + SW'(1);
					count_q     <= count_inc;
					cp_addr_q   <= start_addr;
					cp_left_q   <= eff_w;
					cp_k_q      <= '0;
				end
			end

			if (q_pop && q_cmd.kind == OP_READ) begin
				ones_q    <= '0;
				rd_left_q <= pt_in ? count_q : '0;
				rd_slot_q <= (slot_q == '0) ? SW'(SLOTS - 1) : slot_q - SW'(1);
			end

			// copy: one history read and one snippet write per cycle
			if (state_q == ST_COPY && cp_left_q != '0) begin
				cp_v_s1   <= 1'b1;
				cp_left_q <= cp_left_q - LW'(1);
				cp_k_q    <= cp_k_q + AW'(1);
				cp_addr_q <= (cp_addr_q == AW'(MAX_WINDOW - 1)) ? '0 : cp_addr_q + AW'(1);
			end

			// read walk: newest slot first, one slot per cycle
			if (state_q == ST_READ && rd_left_q != '0) begin
				rd_v_s1   <= 1'b1;
				rd_left_q <= rd_left_q - CW'(1);
				rd_slot_q <= (rd_slot_q == '0) ? SW'(SLOTS - 1) : rd_slot_q - SW'(1);
			end
			if (rd_v_s1) begin
				ones_q <= ones_q + CW'(snip_rd_s1);
			end

			if (emit) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end

			if (cfg_clr) begin
				count_q  <= '0;
				active_q <= 1'b0;
				pos_q    <= '0;
			end
		end
	end

endmodule

// ===== src/edge_triggered_snippet_averager_core.sv =====
// top level of the edge-triggered snippet averager: configuration registers,
// front end queue and back end executor; depends on etsa_pkg, etsa_front, etsa_back
//
// usage:
//   s_axis carries commands: tuser 0 pushes one sample (tdata bit 0), tuser 1
//   reads one window point (tdata bits 10:1). every command gives exactly one
//   m_axis transaction with triggered, snippet_stored, ones_count and
//   averaged_count. the mean at a point is ones_count / averaged_count.
//   configuration is written through cfg_we / cfg_index / cfg_data while the
//   block is idle; any write clears the snippet count and drops a capture.
// command flow (one command at a time in the back end):
//   sample without snippet completion: front queue, idle step, emit step, then the m_axis register
//   sample completing a snippet: held in the back end by the copy of the clamped
//     window of the history into the snippet memory, one bit per cycle on one port
//   read inside the window: held in the back end by the walk over the averaged_count
//     stored slots, one slot per cycle; no walk with nothing stored or a
//     point past the window
//   the back end takes the next queued command only after it has emitted the last
// reset: history reads as zeros, no snippets counted, registers at defaults.
// stall: a full output register holds the back end in its emit step; the
//   two-entry front queue keeps taking commands until it fills, then
//   s_axis_tready drops.
module edge_triggered_snippet_averager_core #(
	parameter int MAX_WINDOW = 1024,
	parameter int SLOTS      = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [0] sample_bit, [10:1] point_index, rest zero
	input  logic        s_axis_tuser,   // [0] op
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [0] triggered, [1] snippet_stored,
	                                    // [6:2] ones_count, [11:7] averaged_count
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import etsa_pkg::*;

	localparam int LW  = $clog2(MAX_WINDOW + 1);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int WXW = (LW > 11) ? LW : 11;
	localparam int MXW = (CW > 5) ? CW : 5;

	// configuration registers
	logic        rising_edge_q;
	logic [9:0]  pre_samples_q;
	logic [10:0] window_length_q;
	logic [4:0]  max_averaged_q;

	// clamped working values
	logic [WXW-1:0] w_clamp;
	logic [WXW-1:0] pre_clamp;
	logic [MXW-1:0] m_clamp;
	logic [LW-1:0]  eff_w;
	logic [LW-1:0]  eff_rem;
	logic [CW-1:0]  eff_max;

	logic   q_valid;
	logic   q_pop;
	cmd_t   q_cmd;
	stat_t  stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rising_edge_q   <= 1'b1;
			pre_samples_q   <= 10'd200;
			window_length_q <= 11'd1024;
			max_averaged_q  <= 5'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				2'(REG_RISING): rising_edge_q   <= cfg_data[0];
				2'(REG_PRE):    pre_samples_q   <= cfg_data[9:0];
				2'(REG_WINDOW): window_length_q <= cfg_data;
				2'(REG_MAXAVG): max_averaged_q  <= cfg_data[4:0];
				default:        rising_edge_q   <= rising_edge_q;
			endcase
		end
	end

	// window clamped to 2..MAX_WINDOW, pre-trigger to window-1, depth to 1..SLOTS
	always_comb begin
		if (WXW'(window_length_q) < WXW'(2)) begin
			w_clamp = WXW'(2);
		end else if (WXW'(window_length_q) > WXW'(MAX_WINDOW)) begin
			w_clamp = WXW'(MAX_WINDOW);
		end else begin
			w_clamp = WXW'(window_length_q);
		end
		if (WXW'(pre_samples_q) > w_clamp - WXW'(1)) begin
			pre_clamp = w_clamp - WXW'(1);
		end else begin
			pre_clamp = WXW'(pre_samples_q);
		end
		if (MXW'(max_averaged_q) < MXW'(1)) begin
			m_clamp = MXW'(1);
		end else if (MXW'(max_averaged_q) > MXW'(SLOTS)) begin
			m_clamp = MXW'(SLOTS);
		end else begin
			m_clamp = MXW'(max_averaged_q);
		end
		eff_w   = LW'(w_clamp);
		// samples still to come after the trigger sample
		eff_rem = LW'(w_clamp - WXW'(1) - pre_clamp);
		eff_max = CW'(m_clamp);
	end

	etsa_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop)
	);

	etsa_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.SLOTS      (SLOTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_clr       (cfg_we),
		.rising        (rising_edge_q),
		.eff_w         (eff_w),
		.eff_rem       (eff_rem),
		.eff_max       (eff_max),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.stat          (stat)
	);

	// a configuration write while idle leaves no snippet counted
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && stat.idle |=> stat.count == 5'd0)
		else $error("snippet count not cleared by configuration write");

	// ones never exceed the number of snippets averaged
	a_ones_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:2] <= m_axis_tdata[11:7])
		else $error("ones_count above averaged_count");

	// a trigger transaction is a sample and carries no read result
	a_trig_no_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[6:2] == 5'd0)
		else $error("trigger result carries ones_count");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the edge-triggered snippet averager core: a scoreboard class
// predicts every result from its own copy of history, snippet slots and registers
// depends on etsa_pkg and edge_triggered_snippet_averager_core
`timescale 1ns / 1ps

module tb_top;
	import etsa_pkg::*;

	localparam int HIST_DEPTH = 1024;
	localparam int SLOT_COUNT = 30;
	localparam int PHASES     = 9;

	// one result as unpacked from m_axis_tdata
	typedef struct {
		bit       triggered;
		bit       snippet_stored;
		bit [4:0] ones_count;
		bit [4:0] averaged_count;
	} avg_result_t;

	// idle modes, stepped through phase by phase
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	class avg_scoreboard;
		bit          hist[HIST_DEPTH];
		int unsigned hist_head;
		bit          snip[SLOT_COUNT][HIST_DEPTH];
		int unsigned slot_ptr;
		int unsigned snip_count;
		bit          capturing;
		int unsigned samples_left;
		bit          last_bit;
		bit          rising;
		bit [9:0]    pre_len;
		bit [10:0]   win_len;
		bit [4:0]    avg_depth;
		avg_result_t expected_q[$];
		int          errors;

		function new();
			rising    = 1;
			pre_len   = 200;
			win_len   = 1024;
			avg_depth = 20;
		endfunction

		// window clamped to 2 .. depth of the history
		function int unsigned window();
			if (win_len < 2)
				return 2;
			if (win_len > HIST_DEPTH)
				return HIST_DEPTH;
			return win_len;
		endfunction

		function int unsigned depth_limit();
			if (avg_depth < 1)
				return 1;
			if (avg_depth > SLOT_COUNT)
				return SLOT_COUNT;
			return avg_depth;
		endfunction

		// any write drops the count and a capture in progress
		function void write_reg(int unsigned idx, bit [10:0] value);
			case (idx)
				REG_RISING: rising    = value[0];
				REG_PRE:    pre_len   = value[9:0];
				REG_WINDOW: win_len   = value;
				REG_MAXAVG: avg_depth = value[4:0];
				default: return;
			endcase
			snip_count   = 0;
			capturing    = 0;
			samples_left = 0;
		endfunction

		function void store_window();
			int unsigned w;
			w = window();
			for (int unsigned k = 0; k < w; k++)
				snip[slot_ptr][k] = hist[(hist_head + HIST_DEPTH - w + k) % HIST_DEPTH];
			slot_ptr = (slot_ptr + 1) % SLOT_COUNT;
			if (snip_count < depth_limit())
				snip_count++;
			else
				snip_count = depth_limit();
		endfunction

		function void note_input(op_e_t op, bit sample, bit [9:0] point);
			avg_result_t r;
			int unsigned w;
			int unsigned pre_eff;
			bit          edge_seen;
			r = '{0, 0, 0, 0};
			if (op == OP_SAMPLE) begin
				hist[hist_head] = sample;
				hist_head = (hist_head + 1) % HIST_DEPTH;
				if (capturing) begin
					if (samples_left > 0)
						samples_left--;
					if (samples_left == 0) begin
						capturing = 0;
						store_window();
						r.snippet_stored = 1;
					end
				end else begin
					edge_seen = rising ? (!last_bit && sample) : (last_bit && !sample);
					if (edge_seen) begin
						w = window();
						pre_eff = (pre_len > w - 1) ? w - 1 : pre_len;
						r.triggered = 1;
						if (w - 1 - pre_eff == 0) begin
							store_window();
							r.snippet_stored = 1;
						end else begin
							capturing    = 1;
							samples_left = w - 1 - pre_eff;
						end
					end
				end
				last_bit = sample;
			end else if (point < window()) begin
				for (int unsigned k = 0; k < snip_count; k++)
					r.ones_count += snip[(slot_ptr + 2 * SLOT_COUNT - 1 - k) % SLOT_COUNT][point];
			end
			r.averaged_count = snip_count;
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string field, int got, int want);
			$display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
			errors++;
		endtask

		task check_result(logic [15:0] data);
			avg_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result, tdata", data, 0);
				return;
			end
			want = expected_q.pop_front();
			if (data[0] !== want.triggered)
				report_mismatch("triggered", data[0], want.triggered);
			if (data[1] !== want.snippet_stored)
				report_mismatch("snippet_stored", data[1], want.snippet_stored);
			if (data[6:2] !== want.ones_count)
				report_mismatch("ones_count", data[6:2], want.ones_count);
			if (data[11:7] !== want.averaged_count)
				report_mismatch("averaged_count", data[11:7], want.averaged_count);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [0] sample_bit, [10:1] point_index
	logic        s_axis_tuser;   // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [0] triggered, [1] snippet_stored,
	                             // [6:2] ones_count, [11:7] averaged_count
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	avg_scoreboard sb;
	idle_mode_t    idle_mode;
	bit            level;

	// register settings per phase: edge, pre-trigger, window, average depth
	// covers the clamps (window 0, 1 and beyond 1024, pre past the window,
	// depth 0 and 31) and the case of a snippet ending at its trigger
	bit [10:0] ph_rising[PHASES] = '{1, 0, 1, 0, 1, 1, 2046, 1, 0};
	bit [10:0] ph_pre[PHASES]    = '{3, 0, 1023, 5, 10, 1000, 2047, 20, 6};
	bit [10:0] ph_window[PHASES] = '{8, 2, 16, 0, 1, 1024, 2047, 40, 25};
	bit [10:0] ph_depth[PHASES]  = '{4, 1, 30, 0, 31, 3, 2047, 7, 12};

	edge_triggered_snippet_averager_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver side: tready changes on the falling edge, stalls per idle mode
	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: m_axis_tready <= ($urandom_range(0, 99) >= 64);
			IDLE_BOTH:     m_axis_tready <= ($urandom_range(0, 99) >= 30);
			default:       m_axis_tready <= 1'b1;
		endcase
	end

	// result transactions are checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// starts and ends at a falling edge; tvalid stays high between
	// back-to-back transactions
	task send_cmd(op_e_t op, bit sample, bit [9:0] point);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SENDER) ? 64 : (idle_mode == IDLE_BOTH) ? 30 : 0;
		if ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < gap_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {5'b0, point, sample};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(op, sample, point);
		@(negedge clk);
	endtask

	// only called with nothing outstanding
	task write_cfg(int unsigned idx, bit [10:0] value);
		s_axis_tvalid <= 1'b0;
		cfg_we        <= 1'b1;
		cfg_index     <= idx;
		cfg_data      <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	task wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// random traffic: runs of equal samples so edges come now and then,
	// reads mostly inside the window
	task random_traffic(int count);
		int unsigned w;
		for (int i = 0; i < count; i++) begin
			w = sb.window();
			if ($urandom_range(0, 99) < 25) begin
				if ($urandom_range(0, 99) < 80)
					send_cmd(OP_READ, $urandom_range(0, 1), $urandom_range(0, w - 1));
				else
					send_cmd(OP_READ, $urandom_range(0, 1), $urandom_range(0, 1023));
			end else begin
				if ($urandom_range(0, 99) < 20)
					level = !level;
				send_cmd(OP_SAMPLE, level, $urandom_range(0, 1023));
			end
		end
	endtask

	initial begin
		sb            = new();
		idle_mode     = IDLE_NONE;
		level         = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = OP_SAMPLE;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b1;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed, reset defaults: first sample of 1 is a rising edge,
		// reads at both ends of the window with nothing stored
		send_cmd(OP_READ, 1'b0, 10'd0);
		send_cmd(OP_READ, 1'b1, 10'd1023);
		send_cmd(OP_SAMPLE, 1'b1, 10'd1023);
		send_cmd(OP_SAMPLE, 1'b0, 10'd0);
		send_cmd(OP_SAMPLE, 1'b1, 10'd0);
		send_cmd(OP_READ, 1'b0, 10'd200);
		wait_drained();

		// directed, short window: edges, snippets, reads in and past the window
		write_cfg(REG_RISING, 11'd1);
		write_cfg(REG_PRE, 11'd2);
		write_cfg(REG_WINDOW, 11'd4);
		write_cfg(REG_MAXAVG, 11'd2);
		for (int i = 0; i < 12; i++)
			send_cmd(OP_SAMPLE, (i % 3) == 1, 10'd0);
		for (int p = 0; p < 4; p++)
			send_cmd(OP_READ, 1'b0, p);
		send_cmd(OP_READ, 1'b0, 10'd4);
		send_cmd(OP_READ, 1'b1, 10'd1023);
		wait_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_cfg(REG_RISING, ph_rising[ph]);
			write_cfg(REG_PRE, ph_pre[ph]);
			write_cfg(REG_WINDOW, ph_window[ph]);
			write_cfg(REG_MAXAVG, ph_depth[ph]);
			idle_mode = idle_mode_t'(ph % 4);
			random_traffic(170);
			wait_drained();
		end

		// outstanding results done, allow the slowest copy to finish
		repeat (1100) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
src/etsa_pkg.sv
src/etsa_front.sv
src/etsa_back.sv
src/edge_triggered_snippet_averager_core.sv
tb/tb_top.sv
